// File: design/dzf_pkg.sv
package dzf_pkg;

  localparam int COORD_BITS_DEF = 24;

  localparam int DZ_W      = 23;
  localparam int SM_W      = 8;
  localparam int WORLD_W   = 23;
  localparam int CFG_W     = 23;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHNESS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORLD_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WORLD_HEIGHT = 2'd3;

  localparam logic [DZ_W-1:0]    DEAD_ZONE_RST  = 23'd5000;
  localparam logic [SM_W-1:0]    SMOOTHNESS_RST = 8'd8;
  localparam logic [WORLD_W-1:0] WORLD_RST      = 23'd2048000;

  typedef struct packed {
    logic [DZ_W-1:0] dead_zone;
    logic [SM_W-1:0] smoothness;
  } axis_cfg_t;

endpackage

// File: design/dzf_if.sv
interface dzf_in_if #(
  parameter int COORD_BITS = dzf_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic                         snap;

  modport source (output valid, output pos_x, output pos_y, output snap, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input snap, output ready);
endinterface

interface dzf_out_if #(
  parameter int COORD_BITS = dzf_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] view_x;
  logic signed [COORD_BITS-1:0] view_y;

  modport source (output valid, output view_x, output view_y, input ready);
  modport sink   (input valid, input view_x, input view_y, output ready);
endinterface

// File: design/dead_zone_follow_smoother.sv
// Two-axis dead-zone camera follower. Each input word carries a tracked
// position in hundredths of a pixel; the follower moves only when the
// position leaves follower +/- dead_zone, the camera then closes the gap by
// (follower - camera) / smoothness rounded half away from zero, and is
// clamped to [dead_zone, world - dead_zone]. One view word comes out per
// input word. A normal word passes from acceptance through the follower
// update, the bit-serial divider that runs in each axis, one quotient bit
// per cycle, the add and the clamp before the output register; a snap word
// skips the divider. Both axes run side by side. The next word is
// taken once the current one has been moved to the output register.
// Configuration writes take effect immediately and belong between words.
module dead_zone_follow_smoother #(
  parameter int COORD_BITS = dzf_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dzf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dzf_pkg::CFG_W-1:0]        cfg_data_i,
  dzf_in_if.sink                           in_i,
  dzf_out_if.source                        out_o
);

  logic [dzf_pkg::DZ_W-1:0]    dead_zone_q;
  logic [dzf_pkg::SM_W-1:0]    smoothness_q;
  logic [dzf_pkg::WORLD_W-1:0] world_w_q;
  logic [dzf_pkg::WORLD_W-1:0] world_h_q;

  dzf_pkg::axis_cfg_t          axis_cfg;

  logic                        busy_q;
  logic                        out_valid_q;
  logic signed [COORD_BITS-1:0] view_x_q;
  logic signed [COORD_BITS-1:0] view_y_q;

  logic                        accept;
  logic                        ack;
  logic                        x_done, y_done;
  logic signed [COORD_BITS-1:0] x_view, y_view;

  assign axis_cfg.dead_zone  = dead_zone_q;
  assign axis_cfg.smoothness = smoothness_q;

  assign in_i.ready   = !busy_q;
  assign accept       = in_i.valid && !busy_q;
  assign ack          = x_done && y_done && (!out_valid_q || out_o.ready);

  assign out_o.valid  = out_valid_q;
  assign out_o.view_x = view_x_q;
  assign out_o.view_y = view_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_zone_q  <= dzf_pkg::DEAD_ZONE_RST;
      smoothness_q <= dzf_pkg::SMOOTHNESS_RST;
      world_w_q    <= dzf_pkg::WORLD_RST;
      world_h_q    <= dzf_pkg::WORLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dzf_pkg::REG_DEAD_ZONE:    dead_zone_q  <= cfg_data_i[dzf_pkg::DZ_W-1:0];
        dzf_pkg::REG_SMOOTHNESS:   smoothness_q <= cfg_data_i[dzf_pkg::SM_W-1:0];
        dzf_pkg::REG_WORLD_WIDTH:  world_w_q    <= cfg_data_i[dzf_pkg::WORLD_W-1:0];
        dzf_pkg::REG_WORLD_HEIGHT: world_h_q    <= cfg_data_i[dzf_pkg::WORLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      view_x_q    <= '0;
      view_y_q    <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (ack) begin
        busy_q <= 1'b0;
      end
      if (ack) begin
        out_valid_q <= 1'b1;
        view_x_q    <= x_view;
        view_y_q    <= y_view;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  dzf_axis #(
    .COORD_BITS (COORD_BITS)
  ) u_axis_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .ack_i   (ack),
    .pos_i   (in_i.pos_x),
    .snap_i  (in_i.snap),
    .cfg_i   (axis_cfg),
    .world_i (world_w_q),
    .done_o  (x_done),
    .view_o  (x_view)
  );

  dzf_axis #(
    .COORD_BITS (COORD_BITS)
  ) u_axis_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .ack_i   (ack),
    .pos_i   (in_i.pos_y),
    .snap_i  (in_i.snap),
    .cfg_i   (axis_cfg),
    .world_i (world_h_q),
    .done_o  (y_done),
    .view_o  (y_view)
  );

  a_axes_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_done == y_done)
    else $error("axis units out of step");

  a_no_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !x_done)
    else $error("axis done without a word in flight");

  a_ack_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ack |=> (out_valid_q && !busy_q))
    else $error("finished word not moved to output");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_q && !x_done))
    else $error("accepted word did not start work");

endmodule

// File: design/dzf_div.sv
module dzf_div #(
  parameter int COORD_BITS = dzf_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [COORD_BITS+1:0]          num_i,
  input  logic [dzf_pkg::SM_W:0]         den_i,
  output logic                           done_o,
  output logic [COORD_BITS+1:0]          quo_o
);

  localparam int NB = COORD_BITS + 2;
  localparam int DW = dzf_pkg::SM_W + 1;
  localparam int CW = $clog2(NB + 1);

  logic [NB-1:0] nq_q;
  logic [DW-1:0] den_q;
  logic [DW-1:0] rem_q;
  logic [CW-1:0] cnt_q;
  logic          run_q;
  logic [DW:0]   rs;
  logic          qbit;

  assign rs     = {rem_q, nq_q[NB-1]};
  assign qbit   = (rs >= {1'b0, den_q});
  assign done_o = run_q && (cnt_q == '0);
  assign quo_o  = nq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
      nq_q  <= '0;
      den_q <= '0;
      rem_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= CW'(NB);
      nq_q  <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_q <= 1'b0;
      end else begin
        // shift one numerator bit in, one quotient bit out
        rem_q <= qbit ? DW'(rs - {1'b0, den_q}) : rs[DW-1:0];
        nq_q  <= {nq_q[NB-2:0], qbit};
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: design/dzf_axis.sv
module dzf_axis #(
  parameter int COORD_BITS = dzf_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          ack_i,
  input  logic signed [COORD_BITS-1:0]  pos_i,
  input  logic                          snap_i,
  input  dzf_pkg::axis_cfg_t            cfg_i,
  input  logic [dzf_pkg::WORLD_W-1:0]   world_i,
  output logic                          done_o,
  output logic signed [COORD_BITS-1:0]  view_o
);

  localparam int C  = COORD_BITS;
  localparam int WW = ((C > dzf_pkg::WORLD_W + 1) ? C : dzf_pkg::WORLD_W + 1) + 3;
  localparam int NB = C + 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FOL   = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_CLAMP = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic signed [WW-1:0] CMAX = {{(WW-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [WW-1:0] CMIN = ~CMAX;

  function automatic logic signed [C-1:0] sat(input logic signed [WW-1:0] v);
    logic signed [C-1:0] r;
    if (v > CMAX) begin
      r = CMAX[C-1:0];
    end else if (v < CMIN) begin
      r = CMIN[C-1:0];
    end else begin
      r = v[C-1:0];
    end
    return r;
  endfunction

  logic [2:0]                 state_q;
  logic signed [C-1:0]        pos_q;
  logic signed [C-1:0]        fol_q;
  logic signed [C-1:0]        cam_q;
  logic                       snap_q;
  logic                       neg_q;

  logic signed [WW-1:0]       pw, fw, cw, dzw, wdw, lo, hi, diff, mag, qw, sum, hib;
  logic [dzf_pkg::SM_W-1:0]   s_eff;
  logic [NB-1:0]              num_d;
  logic [dzf_pkg::SM_W:0]     den_d;
  logic                       div_start;
  logic                       div_done;
  logic [NB-1:0]              quo;

  assign pw    = WW'(pos_q);
  assign fw    = WW'(fol_q);
  assign cw    = WW'(cam_q);
  assign dzw   = $signed(WW'(cfg_i.dead_zone));
  assign wdw   = $signed(WW'(world_i));
  assign lo    = fw - dzw;
  assign hi    = fw + dzw;
  assign hib   = wdw - dzw;
  assign diff  = fw - cw;
  assign mag   = diff[WW-1] ? -diff : diff;
  assign s_eff = (cfg_i.smoothness == '0) ? dzf_pkg::SM_W'(1) : cfg_i.smoothness;
  assign num_d = {mag[C:0], 1'b0} + NB'(s_eff);
  assign den_d = {s_eff, 1'b0};
  assign qw    = $signed(WW'(quo));
  assign sum   = neg_q ? (cw - qw) : (cw + qw);

  assign div_start = (state_q == S_PREP);
  assign done_o    = (state_q == S_DONE);
  assign view_o    = cam_q;

  dzf_div #(
    .COORD_BITS (COORD_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_d),
    .den_i   (den_d),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fol_q   <= '0;
      cam_q   <= '0;
      pos_q   <= '0;
      snap_q  <= 1'b0;
      neg_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            pos_q   <= pos_i;
            snap_q  <= snap_i;
            state_q <= S_FOL;
          end
        end
        S_FOL: begin
          if (snap_q) begin
            fol_q   <= pos_q;
            cam_q   <= pos_q;
            state_q <= S_CLAMP;
          end else begin
            if (pw < lo) begin
              fol_q <= sat(pw + dzw);
            end else if (pw > hi) begin
              fol_q <= sat(pw - dzw);
            end
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          neg_q   <= diff[WW-1];
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_ADD;
          end
        end
        S_ADD: begin
          cam_q   <= sat(sum);
          state_q <= S_CLAMP;
        end
        S_CLAMP: begin
          if (cw < dzw) begin
            cam_q <= sat(dzw);
          end else if (cw > hib) begin
            cam_q <= sat(hib);
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (ack_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
